FILE: rtl/core/grdh_pkg.sv
// Package for the Golomb-Rice delta hash decoder.
// Holds the decode phase and result kind codes and the result control struct.
// Used by grdh_step, grdh_res_fifo and golomb_rice_delta_hash_decoder.
`timescale 1ns / 1ps
`default_nettype none

package grdh_pkg;

  localparam int unsigned CfgW  = 24;
  localparam int unsigned BitsW = CfgW + 3;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_UNARY = 3'd1,
    PH_REM   = 3'd2,
    PH_DONE  = 3'd3,
    PH_ERR   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HASH  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_TRUNC = 2'd2,
    KIND_OVF   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] count;
    kind_e      kind0;
    kind_e      kind1;
  } res_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/grdh_step.sv
// Per-byte decode step: eight bit decisions on the registered decoder state.
// Produces the next state and up to two results for one byte.
// Depends on grdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grdh_step #(
  parameter int unsigned HASH_BITS      = 64,
  parameter int unsigned REMAINDER_BITS = 47,
  localparam int unsigned AccW = (HASH_BITS > REMAINDER_BITS) ? HASH_BITS : REMAINDER_BITS,
  localparam int unsigned CntW = $clog2(AccW + 1),
  localparam int unsigned UnW  = (HASH_BITS > REMAINDER_BITS) ?
                                 (HASH_BITS - REMAINDER_BITS + 1) : 1
) (
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic [grdh_pkg::BitsW-1:0]  total_i,
  input  wire logic [grdh_pkg::BitsW-1:0]  bits_i,
  input  wire grdh_pkg::phase_e            phase_i,
  input  wire logic [AccW-1:0]             acc_i,
  input  wire logic [CntW-1:0]             cnt_i,
  input  wire logic [UnW-1:0]              unary_i,
  input  wire logic [HASH_BITS-1:0]        hash_i,
  output      logic [grdh_pkg::BitsW-1:0]  bits_o,
  output      grdh_pkg::phase_e            phase_o,
  output      logic [AccW-1:0]             acc_o,
  output      logic [CntW-1:0]             cnt_o,
  output      logic [UnW-1:0]              unary_o,
  output      logic [HASH_BITS-1:0]        hash_o,
  output      grdh_pkg::res_ctl_t          res_ctl_o,
  output      logic [HASH_BITS-1:0]        res_hash0_o,
  output      logic [HASH_BITS-1:0]        res_hash1_o
);

  localparam logic [UnW-1:0] Limit = (UnW'(1) << (UnW - 1)) - UnW'(1);

  logic [grdh_pkg::BitsW-1:0]  bits_v;
  grdh_pkg::phase_e            ph_v;
  logic [AccW-1:0]             acc_v;
  logic [CntW-1:0]             cnt_v;
  logic [UnW-1:0]              un_v;
  logic [HASH_BITS-1:0]        hash_v;
  logic [1:0]                  n_v;
  grdh_pkg::kind_e             k0_v;
  grdh_pkg::kind_e             k1_v;
  logic [HASH_BITS-1:0]        h0_v;
  logic [HASH_BITS-1:0]        h1_v;
  logic                        emit_v;
  grdh_pkg::kind_e             ekind_v;
  logic [HASH_BITS-1:0]        ehash_v;
  logic                        fin_v;
  logic [UnW+REMAINDER_BITS-1:0] diff_v;
  logic [grdh_pkg::BitsW:0]    need_v;
  logic                        bit_v;

  always_comb begin
    bits_v  = bits_i;
    ph_v    = phase_i;
    acc_v   = acc_i;
    cnt_v   = cnt_i;
    un_v    = unary_i;
    hash_v  = hash_i;
    n_v     = 2'd0;
    k0_v    = grdh_pkg::KIND_HASH;
    k1_v    = grdh_pkg::KIND_HASH;
    h0_v    = '0;
    h1_v    = '0;
    emit_v  = 1'b0;
    ekind_v = grdh_pkg::KIND_HASH;
    ehash_v = '0;
    fin_v   = 1'b0;
    diff_v  = '0;
    need_v  = '0;
    bit_v   = 1'b0;
    if (ph_v == grdh_pkg::PH_DONE || ph_v == grdh_pkg::PH_ERR) begin
      n_v = 2'd0;
    end else if (bits_v >= total_i) begin
      ph_v = grdh_pkg::PH_ERR;
      n_v  = 2'd1;
      k0_v = grdh_pkg::KIND_TRUNC;
    end else begin
      for (int i = 7; i >= 0; i--) begin
        bit_v   = data_byte_i[3'(i)];
        emit_v  = 1'b0;
        ekind_v = grdh_pkg::KIND_HASH;
        ehash_v = '0;
        fin_v   = 1'b0;
        if (ph_v == grdh_pkg::PH_FIRST || ph_v == grdh_pkg::PH_UNARY ||
            ph_v == grdh_pkg::PH_REM) begin
          bits_v = bits_v + grdh_pkg::BitsW'(1);
          case (ph_v)
            grdh_pkg::PH_FIRST: begin
              acc_v = {acc_v[AccW-2:0], bit_v};
              cnt_v = cnt_v + CntW'(1);
              if (cnt_v >= CntW'(HASH_BITS)) begin
                hash_v  = acc_v[HASH_BITS-1:0];
                emit_v  = 1'b1;
                ehash_v = hash_v;
                fin_v   = 1'b1;
              end
            end
            grdh_pkg::PH_UNARY: begin
              if (bit_v) begin
                if (un_v <= Limit) begin
                  un_v = un_v + UnW'(1);
                end
              end else if (un_v > Limit) begin
                ph_v    = grdh_pkg::PH_ERR;
                emit_v  = 1'b1;
                ekind_v = grdh_pkg::KIND_OVF;
              end else begin
                ph_v  = grdh_pkg::PH_REM;
                acc_v = '0;
                cnt_v = '0;
              end
            end
            grdh_pkg::PH_REM: begin
              acc_v = {acc_v[AccW-2:0], bit_v};
              cnt_v = cnt_v + CntW'(1);
              if (cnt_v >= CntW'(REMAINDER_BITS)) begin
                diff_v  = {un_v, acc_v[REMAINDER_BITS-1:0]};
                hash_v  = hash_v + diff_v[HASH_BITS-1:0];
                emit_v  = 1'b1;
                ehash_v = hash_v;
                fin_v   = 1'b1;
              end
            end
            default: begin
              ph_v = grdh_pkg::PH_ERR;
            end
          endcase
          if (emit_v) begin
            if (n_v == 2'd0) begin
              k0_v = ekind_v;
              h0_v = ehash_v;
              n_v  = 2'd1;
            end else if (n_v == 2'd1) begin
              k1_v = ekind_v;
              h1_v = ehash_v;
              n_v  = 2'd2;
            end
          end
          if (fin_v) begin
            need_v = {1'b0, bits_v} + (grdh_pkg::BitsW + 1)'(REMAINDER_BITS);
            if ({1'b0, total_i} > need_v) begin
              ph_v = grdh_pkg::PH_UNARY;
              un_v = '0;
            end else begin
              ph_v = grdh_pkg::PH_DONE;
              if (n_v == 2'd0) begin
                k0_v = grdh_pkg::KIND_OK;
                h0_v = '0;
                n_v  = 2'd1;
              end else if (n_v == 2'd1) begin
                k1_v = grdh_pkg::KIND_OK;
                h1_v = '0;
                n_v  = 2'd2;
              end
            end
            acc_v = '0;
            cnt_v = '0;
          end
        end
      end
      if ((ph_v == grdh_pkg::PH_FIRST || ph_v == grdh_pkg::PH_UNARY ||
           ph_v == grdh_pkg::PH_REM) && bits_v >= total_i) begin
        ph_v = grdh_pkg::PH_ERR;
        if (n_v == 2'd0) begin
          k0_v = grdh_pkg::KIND_TRUNC;
          h0_v = '0;
          n_v  = 2'd1;
        end else if (n_v == 2'd1) begin
          k1_v = grdh_pkg::KIND_TRUNC;
          h1_v = '0;
          n_v  = 2'd2;
        end
      end
    end
  end

  assign bits_o          = bits_v;
  assign phase_o         = ph_v;
  assign acc_o           = acc_v;
  assign cnt_o           = cnt_v;
  assign unary_o         = un_v;
  assign hash_o          = hash_v;
  assign res_ctl_o.count = n_v;
  assign res_ctl_o.kind0 = k0_v;
  assign res_ctl_o.kind1 = k1_v;
  assign res_hash0_o     = h0_v;
  assign res_hash1_o     = h1_v;

endmodule

`default_nettype wire

FILE: rtl/core/grdh_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per handshake.
// Marks the last result of each byte. Depends on grdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grdh_res_fifo #(
  parameter int unsigned HASH_BITS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire grdh_pkg::res_ctl_t    push_ctl_i,
  input  wire logic [HASH_BITS-1:0]  push_hash0_i,
  input  wire logic [HASH_BITS-1:0]  push_hash1_i,
  output      logic                  room_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [1:0]            result_kind_o,
  output      logic [HASH_BITS-1:0]  hash_value_o,
  output      logic                  end_of_run_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  grdh_pkg::kind_e       kind_q [Depth];
  logic [HASH_BITS-1:0]  hash_q [Depth];
  logic                  eor_q  [Depth];
  logic [PtrW-1:0]       wr_q, wr_d;
  logic [PtrW-1:0]       rd_q, rd_d;
  logic [PtrW:0]         cnt_q, cnt_d;
  logic [1:0]            n_in;
  logic                  pop;
  logic [PtrW-1:0]       wr_nx;

  assign n_in   = push_i ? push_ctl_i.count : 2'd0;
  assign pop    = out_valid_o && out_ready_i;
  assign wr_nx  = wr_q + PtrW'(1);
  assign wr_d   = wr_q + PtrW'(n_in);
  assign rd_d   = rd_q + PtrW'(pop);
  assign cnt_d  = cnt_q + (PtrW + 1)'(n_in) - (PtrW + 1)'(pop);
  assign room_o = cnt_q <= (PtrW + 1)'(Depth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) begin
      kind_q[wr_q] <= push_ctl_i.kind0;
      hash_q[wr_q] <= push_hash0_i;
      eor_q[wr_q]  <= (n_in == 2'd1);
    end
    if (n_in == 2'd2) begin
      kind_q[wr_nx] <= push_ctl_i.kind1;
      hash_q[wr_nx] <= push_hash1_i;
      eor_q[wr_nx]  <= 1'b1;
    end
  end

  assign out_valid_o   = cnt_q != '0;
  assign result_kind_o = kind_q[rd_q];
  assign hash_value_o  = hash_q[rd_q];
  assign end_of_run_o  = eor_q[rd_q];

endmodule

`default_nettype wire

FILE: rtl/core/golomb_rice_delta_hash_decoder.sv
// Path: an accepted byte is held in the input register, decoded when the result
// queue has room, and its results are offered from the result queue.
// Throughput: one byte per cycle while the queue has room; a byte with two results
// takes two output handshakes, and input stalls while the queue has under two free slots.
// Reset: clears the decoder state, the queue and the length register (0).
// Depends on grdh_pkg, grdh_step and grdh_res_fifo.
`timescale 1ns / 1ps
`default_nettype none

module golomb_rice_delta_hash_decoder #(
  parameter int unsigned HASH_BITS      = 64,
  parameter int unsigned REMAINDER_BITS = 47
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [grdh_pkg::CfgW-1:0]    cfg_stream_bytes_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [7:0]                   data_byte_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [1:0]                   result_kind_o,
  output      logic [HASH_BITS-1:0]         hash_value_o,
  output      logic                         end_of_run_o
);

  localparam int unsigned AccW = (HASH_BITS > REMAINDER_BITS) ? HASH_BITS : REMAINDER_BITS;
  localparam int unsigned CntW = $clog2(AccW + 1);
  localparam int unsigned UnW  = (HASH_BITS > REMAINDER_BITS) ?
                                 (HASH_BITS - REMAINDER_BITS + 1) : 1;

  logic [grdh_pkg::CfgW-1:0]   len_q;
  logic                        vld_q;
  logic [7:0]                  byte_q;
  logic [grdh_pkg::BitsW-1:0]  bits_q, bits_d;
  grdh_pkg::phase_e            phase_q, phase_d;
  logic [AccW-1:0]             acc_q, acc_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [UnW-1:0]              unary_q, unary_d;
  logic [HASH_BITS-1:0]        hash_q, hash_d;
  grdh_pkg::res_ctl_t          res_ctl;
  logic [HASH_BITS-1:0]        res_hash0;
  logic [HASH_BITS-1:0]        res_hash1;
  logic                        room;
  logic                        advance;
  logic [grdh_pkg::BitsW-1:0]  total;

  assign cfg_ready_o = 1'b1;
  assign total       = {len_q, 3'b000};
  assign advance     = vld_q && room;
  assign in_ready_o  = !vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      len_q <= cfg_stream_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      phase_q <= grdh_pkg::PH_FIRST;
      acc_q   <= '0;
      cnt_q   <= '0;
      unary_q <= '0;
      hash_q  <= '0;
    end else if (advance) begin
      bits_q  <= bits_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      unary_q <= unary_d;
      hash_q  <= hash_d;
    end
  end

  grdh_step #(
    .HASH_BITS      (HASH_BITS),
    .REMAINDER_BITS (REMAINDER_BITS)
  ) u_step (
    .data_byte_i (byte_q),
    .total_i     (total),
    .bits_i      (bits_q),
    .phase_i     (phase_q),
    .acc_i       (acc_q),
    .cnt_i       (cnt_q),
    .unary_i     (unary_q),
    .hash_i      (hash_q),
    .bits_o      (bits_d),
    .phase_o     (phase_d),
    .acc_o       (acc_d),
    .cnt_o       (cnt_d),
    .unary_o     (unary_d),
    .hash_o      (hash_d),
    .res_ctl_o   (res_ctl),
    .res_hash0_o (res_hash0),
    .res_hash1_o (res_hash1)
  );

  grdh_res_fifo #(
    .HASH_BITS (HASH_BITS)
  ) u_res_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (advance),
    .push_ctl_i    (res_ctl),
    .push_hash0_i  (res_hash0),
    .push_hash1_i  (res_hash1),
    .room_o        (room),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .hash_value_o  (hash_value_o),
    .end_of_run_o  (end_of_run_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_golomb_rice_delta_hash_decoder.sv
`timescale 1ns / 1ps
// Testbench for golomb_rice_delta_hash_decoder: streams a Golomb-Rice coded hash list
// byte by byte and checks every decoded hash and end status against an in-bench decoder.
// Depends on grdh_pkg and the decoder RTL; needs no files or arguments.
module tb_golomb_rice_delta_hash_decoder;

  localparam int unsigned HashW       = 64;
  localparam int unsigned RemW        = 47;
  localparam int unsigned PrefixLimit = 32'(64'hFFFF_FFFF_FFFF_FFFF >> RemW);
  localparam logic [23:0] MaxLen      = 24'hFF_FFFF;
  localparam int unsigned ItemTarget  = 1900;
  localparam int unsigned BreakEvery  = 350;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned MaxReports  = 10;

  typedef struct {
    grdh_pkg::kind_e kind;
    logic [63:0]     hash;
    logic            run_end;
  } hash_result_t;

  typedef enum {END_SHORT_LEN, END_ZERO_LEN, END_IN_FIELD} ending_e;

  class hash_list_board;
    hash_result_t     pending_results[$];
    hash_result_t     byte_results[$];
    logic [23:0]      stream_len;
    logic [26:0]      bits_used;
    grdh_pkg::phase_e phase;
    logic [63:0]      field_acc;
    int unsigned      field_n;
    logic [17:0]      prefix;
    logic [63:0]      run_hash;
    int unsigned      errors;
    int unsigned      checked;

    function new();
      stream_len = '0;
      bits_used  = '0;
      phase      = grdh_pkg::PH_FIRST;
      field_acc  = '0;
      field_n    = 0;
      prefix     = '0;
      run_hash   = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_length(logic [23:0] len);
      stream_len = len;
    endfunction

    function bit finished();
      return phase == grdh_pkg::PH_DONE || phase == grdh_pkg::PH_ERR;
    endfunction

    function void add(grdh_pkg::kind_e k, logic [63:0] h);
      hash_result_t r;
      r.kind    = k;
      r.hash    = h;
      r.run_end = 1'b0;
      if (byte_results.size() < 2) byte_results.insert(byte_results.size(), r);
    endfunction

    function void close_field();
      logic [26:0] total;
      total = {stream_len, 3'b000};
      if (total > bits_used && total - bits_used > RemW) begin
        phase  = grdh_pkg::PH_UNARY;
        prefix = '0;
      end else begin
        phase = grdh_pkg::PH_DONE;
        add(grdh_pkg::KIND_OK, '0);
      end
      field_acc = '0;
      field_n   = 0;
    endfunction

    function void take_byte(logic [7:0] data);
      logic [26:0] total;
      logic [63:0] diff;
      int i;
      total = {stream_len, 3'b000};
      byte_results.delete();
      if (finished()) return;
      if (bits_used >= total) begin
        phase = grdh_pkg::PH_ERR;
        add(grdh_pkg::KIND_TRUNC, '0);
      end else begin
        for (i = 7; i >= 0; i--) begin
          if (finished()) break;
          bits_used++;
          case (phase)
            grdh_pkg::PH_FIRST: begin
              field_acc = {field_acc[62:0], data[i]};
              field_n++;
              if (field_n >= HashW) begin
                run_hash = field_acc;
                add(grdh_pkg::KIND_HASH, run_hash);
                close_field();
              end
            end
            grdh_pkg::PH_UNARY: begin
              if (data[i]) begin
                if (prefix <= PrefixLimit) prefix++;
              end else if (prefix > PrefixLimit) begin
                phase = grdh_pkg::PH_ERR;
                add(grdh_pkg::KIND_OVF, '0);
              end else begin
                phase     = grdh_pkg::PH_REM;
                field_acc = '0;
                field_n   = 0;
              end
            end
            default: begin
              field_acc = {field_acc[62:0], data[i]};
              field_n++;
              if (field_n >= RemW) begin
                diff     = (64'(prefix) << RemW) + field_acc;
                run_hash = run_hash + diff;
                add(grdh_pkg::KIND_HASH, run_hash);
                close_field();
              end
            end
          endcase
        end
        if (!finished() && bits_used >= total) begin
          phase = grdh_pkg::PH_ERR;
          add(grdh_pkg::KIND_TRUNC, '0);
        end
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
      foreach (byte_results[k])
        pending_results.insert(pending_results.size(), byte_results[k]);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MaxReports) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [1:0] kind, logic [63:0] hash, logic run_end);
      hash_result_t want;
      if (pending_results.size() == 0) begin
        note_error($sformatf("result with none expected: kind %0d hash %h end %0b",
                             kind, hash, run_end));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (kind !== want.kind || hash !== want.hash || run_end !== want.run_end)
        note_error($sformatf("result %0d: expected kind %s hash %h end %0b, got kind %0d hash %h end %0b",
                             checked, want.kind.name(), want.hash, want.run_end,
                             kind, hash, run_end));
    endfunction
  endclass

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        cfg_valid_i        = 1'b0;
  logic [23:0] cfg_stream_bytes_i = '0;
  logic        in_valid_i         = 1'b0;
  logic [7:0]  data_byte_i        = '0;
  logic        out_ready_i        = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  result_kind_o;
  logic [63:0] hash_value_o;
  logic        end_of_run_o;

  hash_list_board board;
  bit             stream_bits[$];
  int unsigned    bytes_sent    = 0;
  int unsigned    length_writes = 0;
  int unsigned    idle_cycles   = 0;
  bit             burst_mode    = 1'b0;
  bit             hold_out_req  = 1'b0;

  golomb_rice_delta_hash_decoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_stream_bytes_i(cfg_stream_bytes_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .hash_value_o      (hash_value_o),
    .end_of_run_o      (end_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void add_bits(logic [63:0] v, int unsigned n);
    int i;
    for (i = n - 1; i >= 0; i--) stream_bits.insert(stream_bits.size(), v[i]);
  endfunction

  function automatic void add_code(int unsigned q, logic [46:0] rem);
    repeat (q) stream_bits.insert(stream_bits.size(), 1'b1);
    stream_bits.insert(stream_bits.size(), 1'b0);
    add_bits(64'(rem), RemW);
  endfunction

  function automatic void add_random_code();
    int unsigned q;
    q = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
    add_code(q, 47'({$urandom, $urandom}));
  endfunction

  task automatic send_byte(input logic [7:0] data);
    int unsigned gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_byte(data);
    bytes_sent++;
  endtask

  task automatic send_bits();
    logic [7:0] data;
    int i;
    while (stream_bits.size() >= 8 && !board.finished()) begin
      for (i = 7; i >= 0; i--) data[i] = stream_bits.pop_front();
      send_byte(data);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [23:0] len);
    drain();
    cfg_valid_i        <= 1'b1;
    cfg_stream_bytes_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_length(len);
    length_writes++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
      board.check_result(result_kind_o, hash_value_o, end_of_run_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no handshake for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned run;
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
        out_ready_i <= 1'b1;
        repeat (run) @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int unsigned target;
    int unsigned next_break;
    bit          hold_done;
    logic [31:0] len;
    ending_e     ending;
    int unsigned errors;
    board      = new();
    target     = ItemTarget;
    next_break = BreakEvery;
    hold_done  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_length(MaxLen);
    add_bits(64'hFFFF_FFFF_FFFF_FFFF, HashW);
    add_code(0, 47'd1);
    add_code(2, '1);
    add_code(0, '0);
    send_bits();

    while (bytes_sent < target && !board.finished()) begin
      if (bytes_sent >= next_break) begin
        next_break += BreakEvery;
        len = (board.bits_used >> 3) + $urandom_range(40000, 4000000);
        if (len > MaxLen || $urandom_range(0, 3) == 0) len = MaxLen;
        write_length(len[23:0]);
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      if (!hold_done && bytes_sent >= 500) begin
        hold_out_req = 1'b1;
        hold_done    = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) add_random_code();
      else add_bits(64'($urandom_range(0, 255)), 8);
      send_bits();
    end

    burst_mode = 1'b0;
    ending     = ending_e'($urandom_range(0, 2));
    case (ending)
      END_SHORT_LEN: begin
        len = (board.bits_used >> 3) + $urandom_range(0, 14);
        write_length(len[23:0]);
        while (!board.finished()) begin
          add_random_code();
          send_bits();
        end
      end
      END_ZERO_LEN: begin
        write_length('0);
        send_byte(8'($urandom));
      end
      default: begin
        len = (board.bits_used >> 3) + $urandom_range(1, 30);
        write_length(len[23:0]);
        while (!board.finished())
          send_byte((board.phase == grdh_pkg::PH_UNARY) ? 8'hFF : 8'($urandom));
      end
    endcase

    repeat (4) send_byte(8'($urandom));
    write_length('0);
    repeat (3) send_byte(8'($urandom));
    drain();

    errors = board.errors + board.pending_results.size();
    $display("Summary: %0d bytes accepted, %0d results checked, %0d length writes",
             bytes_sent, board.checked, length_writes);
    $display("Summary: stream closed via %s, decoder left in %s",
             ending.name(), board.phase.name());
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
